// File: design/lap3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared constants, types and the per-channel Laplacian arithmetic for the
// 3x3 RGB sharpen / edge filter.
// ----------------------------------------------------------------------------
package lap3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);       // line store address
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);   // width register
  localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);  // height register
  localparam int IN_ROW_W   = $clog2(MAX_HEIGHT + 2);  // input row runs into the flush
  localparam int OUT_ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // one line store entry: pixel two lines up and pixel one line up
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_entry_t;

  typedef struct packed {
    logic edge_mode;
    logic border;
    logic last;
  } kern_ctrl_t;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } result_t;

  // K*centre minus the eight neighbours, clamped to 0..255 (K = 8 or 9)
  function automatic logic [7:0] lap_chan(input logic [8:0][7:0] v,
                                          input logic edge_mode);
    logic [11:0]        nsum;
    logic [11:0]        kc;
    logic signed [13:0] diff;
    logic [7:0]         res;
    int                 i;
    nsum = '0;
    for (i = 0; i < 9; i++) begin
      if (i != 4) nsum = nsum + {4'b0, v[i]};
    end
    kc = {1'b0, v[4], 3'b000} + (edge_mode ? 12'd0 : {4'b0, v[4]});
    diff = $signed({2'b00, kc}) - $signed({2'b00, nsum});
    if (diff < 0) begin
      res = 8'd0;
    end else if (diff > 14'sd255) begin
      res = 8'd255;
    end else begin
      res = diff[7:0];
    end
    return res;
  endfunction

endpackage

// File: design/rgb_3x3_laplacian_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_laplacian_filter_top
// RGB 3x3 Laplacian sharpen / edge filter on a raster pixel stream.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------
//   s_axis   | s_axis_tvalid/s_axis_tready  | tdata red,green,blue; tuser fill
//   m_axis   | m_axis_tvalid/m_axis_tready  | tdata red,green,blue; tlast
//   cfg      | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One pixel per clock while the output buffer has room, set by the single
// read-modify-write of the line RAM per pixel. A result reaches m_axis from
// the transfer of the pixel that releases it through the RAM read, then the
// window shift, then the kernel into the output buffer. Reset is synchronous;
// the line RAM needs no clearing pass since every entry whose value reaches a
// result was written earlier in that frame. A stall on m_axis is absorbed by a
// 2-entry output buffer; s_axis_tready drops only when it fills.
// ----------------------------------------------------------------------------
module rgb_3x3_laplacian_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tuser,   // fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tlast,   // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lap3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lap3_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lap3_pkg::*;

  // configuration, held as effective (clamped) values
  logic                mode;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  logic [COL_W-1:0]     in_column;
  logic [IN_ROW_W-1:0]  in_row;
  logic [COL_W-1:0]     out_column;
  logic [OUT_ROW_W-1:0] out_row;

  logic ce, acc, cfg_hit;
  logic emit, col_wrap, row_last, col_last, border, last;
  pixel_t cur;

  // stage 1: RAM read data arrives
  logic             s1_valid, s1_emit, s1_border, s1_last, s1_hz;
  logic [COL_W-1:0] s1_col;
  pixel_t           s1_cur;

  line_entry_t rd_data, wr_data, wr_prev;
  pixel_t      up_e, mid_e;
  logic        wr_en;

  // stage 2: window and kernel
  pixel_t     win [9];
  logic       s2_valid;
  kern_ctrl_t s2_ctrl;
  result_t    kres;

  // output buffer
  result_t    q0, q1;
  logic [1:0] cnt;
  logic       push, pop;

  assign cfg_ready     = 1'b1;
  assign ce            = (cnt != 2'd2);
  assign s_axis_tready = ce;
  assign acc           = s_axis_tvalid & ce;
  assign cfg_hit       = cfg_valid && (cfg_reg_t'(cfg_index) == REG_MODE ||
                                       cfg_reg_t'(cfg_index) == REG_WIDTH ||
                                       cfg_reg_t'(cfg_index) == REG_HEIGHT);

  always_comb begin
    cur = s_axis_tuser ? '0 : pixel_t'({s_axis_tdata[23:16], s_axis_tdata[15:8],
                                        s_axis_tdata[7:0]});
    emit     = (in_row >= IN_ROW_W'(2)) || (in_row == IN_ROW_W'(1) && in_column != '0);
    col_wrap = ({1'b0, in_column} + WIDTH_W'(1)) >= eff_w;
    row_last = ({1'b0, out_row} + HEIGHT_W'(1)) >= eff_h;
    col_last = ({1'b0, out_column} + WIDTH_W'(1)) >= eff_w;
    border   = (out_row == '0) || row_last || (out_column == '0) || col_last;
    last     = row_last && col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      eff_w <= WIDTH_RESET;
      eff_h <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE: mode <= cfg_data[0];
        REG_WIDTH: begin
          if (cfg_data[WIDTH_W-1:0] == '0) eff_w <= WIDTH_W'(1);
          else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) eff_w <= WIDTH_W'(MAX_WIDTH);
          else eff_w <= cfg_data[WIDTH_W-1:0];
        end
        REG_HEIGHT: begin
          if (cfg_data[HEIGHT_W-1:0] == '0) eff_h <= HEIGHT_W'(1);
          else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT))
            eff_h <= HEIGHT_W'(MAX_HEIGHT);
          else eff_h <= cfg_data[HEIGHT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // frame position counters, all resolved at the input transfer
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (acc) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + IN_ROW_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
        if (emit) begin
          if (col_last) begin
            out_column <= '0;
            out_row    <= out_row + OUT_ROW_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
        end
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_hz    <= 1'b0;
    end else if (ce) begin
      s1_valid <= acc;
      // one-pixel lines and a frame restart hit the same entry back to back
      s1_hz    <= acc && s1_valid && (s1_col == in_column);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col    <= in_column;
      s1_cur    <= cur;
      s1_emit   <= emit;
      s1_border <= border;
      s1_last   <= last;
    end
  end

  lap3_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (in_column),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  always_comb begin
    up_e           = s1_hz ? wr_prev.upper  : rd_data.upper;
    mid_e          = s1_hz ? wr_prev.middle : rd_data.middle;
    wr_en          = ce && s1_valid;
    wr_data.upper  = mid_e;
    wr_data.middle = s1_cur;
  end

  always_ff @(posedge clk) begin
    if (wr_en) wr_prev <= wr_data;
  end

  // window shift, new column on the right
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= up_e;
      win[5] <= mid_e;
      win[8] <= s1_cur;
      s2_ctrl.edge_mode <= mode;
      s2_ctrl.border    <= s1_border;
      s2_ctrl.last      <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (ce) s2_valid <= s1_valid && s1_emit;
  end

  lap3_kernel u_kernel (
    .win  (win),
    .ctrl (s2_ctrl),
    .res  (kres)
  );

  // 2-entry output buffer
  assign push = ce && s2_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (cnt == 2'd1) q0 <= kres;
        else begin
          q0 <= q1;
          q1 <= kres;
        end
      end
      2'b10: begin
        if (cnt == 2'd0) q0 <= kres;
        else q1 <= kres;
      end
      2'b01:   q0 <= q1;
      default: ;
    endcase
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = {q0.px.blue, q0.px.green, q0.px.red};
  assign m_axis_tlast  = q0.last;

  // forwarding only ever follows a live stage 1 write
  a_hz_valid: assert property (@(posedge clk) disable iff (rst)
    s1_hz |-> s1_valid)
    else $error("line RAM forwarding without a stage 1 transfer");

  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_column} < eff_w)
    else $error("input column beyond line width");

  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, out_row} < eff_h)
    else $error("output row beyond frame height");

  a_buf_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2)
    else $error("output buffer changed while full and stalled");

endmodule

// File: design/lap3_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_line_ram
// Line store: one entry per column holding the two previous lines. One write
// port, one read port with registered read data (read-before-write).
// ----------------------------------------------------------------------------
module lap3_line_ram (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [lap3_pkg::COL_W-1:0] rd_addr,
  output lap3_pkg::line_entry_t     rd_data,
  input  logic                      wr_en,
  input  logic [lap3_pkg::COL_W-1:0] wr_addr,
  input  lap3_pkg::line_entry_t     wr_data
);
  import lap3_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: design/lap3_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap3_kernel
// 3x3 Laplacian on one window of RGB pixels, with the border rule of the
// selected mode (pass-through for sharpen, zero for edge).
// ----------------------------------------------------------------------------
module lap3_kernel (
  input  lap3_pkg::pixel_t     win [9],
  input  lap3_pkg::kern_ctrl_t ctrl,
  output lap3_pkg::result_t    res
);
  import lap3_pkg::*;

  logic [8:0][7:0] rv, gv, bv;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rv[i] = win[i].red;
      gv[i] = win[i].green;
      bv[i] = win[i].blue;
    end
  end

  always_comb begin
    res.last = ctrl.last;
    if (ctrl.border) begin
      res.px = ctrl.edge_mode ? '0 : win[4];
    end else begin
      res.px.red   = lap_chan(rv, ctrl.edge_mode);
      res.px.green = lap_chan(gv, ctrl.edge_mode);
      res.px.blue  = lap_chan(bv, ctrl.edge_mode);
    end
  end

endmodule
